>>> src/degree_sequence_graphical_test_defines.svh
// Assertion macros shared by the degree sequence test RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef DEGREE_SEQUENCE_GRAPHICAL_TEST_DEFINES_SVH
`define DEGREE_SEQUENCE_GRAPHICAL_TEST_DEFINES_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define DSGT_ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("degree sequence test: assertion failed");
// A condition that, when true, implies a consequence in the same cycle.
`define DSGT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("degree sequence test: assertion failed");
`else
`define DSGT_ASSERT_HOLDS(lbl, clk, rst, prop)
`define DSGT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/dsgt_pkg.sv
// Shared types and constants for the degree sequence graphical test.
// No dependencies; every module of the block imports this package.
`default_nettype none

package dsgt_pkg;

  // Fixed field geometry of one item.
  localparam int NUM_FIELDS = 10;
  localparam int DEG_W      = 5;
  localparam int VAL_W      = 4;
  localparam int CNT_W      = 4;
  localparam int RANK_W     = 4;
  localparam int SUM_W      = 7;

  // Failure codes, in the order the checks are applied.
  localparam logic [1:0] FR_PASS   = 2'd0;
  localparam logic [1:0] FR_RANGE  = 2'd1;
  localparam logic [1:0] FR_ODD    = 2'd2;
  localparam logic [1:0] FR_PREFIX = 2'd3;

  typedef logic [VAL_W-1:0]  deg_val_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // An item after the range and parity checks; unused degrees are zero.
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic [1:0]                   reason;
    deg_val_t [NUM_FIELDS-1:0]    deg;
  } dsgt_item_t;

  // Both sides of every prefix inequality, index k standing for k+1 vertices.
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic [1:0]                   reason;
    sum_t [NUM_FIELDS-1:0]        pref;
    sum_t [NUM_FIELDS-1:0]        rhs;
  } dsgt_bound_t;

endpackage

`default_nettype wire

>>> src/dsgt_check.sv
// First pipeline stage: count saturation, degree range check and sum parity.
// Depends on dsgt_pkg and the assertion macro header.
`default_nettype none
`include "degree_sequence_graphical_test_defines.svh"

module dsgt_check
  import dsgt_pkg::*;
#(
  parameter int MAX_ENTRIES = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  in_valid,
  input  logic [CNT_W-1:0]                      entry_count,
  input  logic [NUM_FIELDS-1:0][DEG_W-1:0]      raw_deg,
  output logic                                  stage_valid,
  output dsgt_item_t                            stage_item
);

  dsgt_item_t item_next;

  // Range check over the used fields and parity of their sum.
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic             used;
    logic             range_bad;
    logic             parity;
    cnt = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
    range_bad = 1'b0;
    parity    = 1'b0;
    item_next = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      used = (CNT_W'(i) < cnt);
      if (used && (raw_deg[i][DEG_W-1] || (raw_deg[i][VAL_W-1:0] >= cnt))) begin
        range_bad = 1'b1;
      end
      item_next.deg[i] = used ? raw_deg[i][VAL_W-1:0] : '0;
      parity = parity ^ item_next.deg[i][0];
    end
    item_next.count = cnt;
    if (range_bad) begin
      item_next.reason = FR_RANGE;
    end else if (parity) begin
      item_next.reason = FR_ODD;
    end else begin
      item_next.reason = FR_PASS;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_item <= item_next;
    end
  end

  // An empty sequence can never fail the first two checks.
  `DSGT_ASSERT_IMPLIES(a_empty_passes, clk, rst, stage_valid && stage_item.count == '0, stage_item.reason == FR_PASS)

endmodule

`default_nettype wire

>>> src/dsgt_sort.sv
// Descending sort in two stages: rank by comparison, then scatter by rank.
// Depends on dsgt_pkg and the assertion macro header.
`default_nettype none
`include "degree_sequence_graphical_test_defines.svh"

module dsgt_sort
  import dsgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance_rank,
  input  logic        advance_scatter,
  input  logic        in_valid,
  input  dsgt_item_t  in_item,
  output logic        rank_valid,
  output logic        sorted_valid,
  output dsgt_item_t  sorted_item
);

  rank_t [NUM_FIELDS-1:0] rank_next;
  rank_t [NUM_FIELDS-1:0] rank;
  dsgt_item_t             rank_item;
  dsgt_item_t             sorted_next;

  // Rank of each degree: how many are larger, ties broken by position.
  always_comb begin
    logic gt;
    rank_next = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      for (int j = 0; j < NUM_FIELDS; j++) begin
        gt = (j != i) && ((in_item.deg[j] > in_item.deg[i]) ||
                          ((in_item.deg[j] == in_item.deg[i]) && (j < i)));
        rank_next[i] = rank_next[i] + RANK_W'(gt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_valid <= 1'b0;
    end else if (advance_rank) begin
      rank_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_rank) begin
      rank      <= rank_next;
      rank_item <= in_item;
    end
  end

  // Ranks form a permutation, so each slot collects exactly one degree.
  always_comb begin
    deg_val_t acc;
    sorted_next = rank_item;
    for (int r = 0; r < NUM_FIELDS; r++) begin
      acc = '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (rank[i] == RANK_W'(r)) begin
          acc = acc | rank_item.deg[i];
        end
      end
      sorted_next.deg[r] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (advance_scatter) begin
      sorted_valid <= rank_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_scatter) begin
      sorted_item <= sorted_next;
    end
  end

  // The first sorted slot holds the largest degree.
  `DSGT_ASSERT_IMPLIES(a_sorted_order, clk, rst, sorted_valid, sorted_item.deg[0] >= sorted_item.deg[NUM_FIELDS-1])

endmodule

`default_nettype wire

>>> src/dsgt_ineq.sv
// Prefix inequality stages: both sides for every k, then the compare and
// the final result register. Depends on dsgt_pkg.
`default_nettype none

module dsgt_ineq
  import dsgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance_sum,
  input  logic        advance_out,
  input  logic        in_valid,
  input  dsgt_item_t  in_item,
  output logic        sum_valid,
  output logic        out_valid,
  output logic        is_graphical,
  output logic [1:0]  fail_reason
);

  dsgt_bound_t bound_next;
  dsgt_bound_t bound;
  logic [1:0]  reason_next;

  // Prefix sums and k(k-1) plus the clipped tail sum for every k.
  always_comb begin
    sum_t     run;
    sum_t     tail;
    deg_val_t kval;
    bound_next        = '0;
    bound_next.count  = in_item.count;
    bound_next.reason = in_item.reason;
    run = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      run = run + SUM_W'(in_item.deg[k]);
      bound_next.pref[k] = run;
      kval = VAL_W'(k + 1);
      tail = SUM_W'((k + 1) * k);
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (i > k) begin
          tail = tail + SUM_W'((in_item.deg[i] < kval) ? in_item.deg[i] : kval);
        end
      end
      bound_next.rhs[k] = tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (advance_sum) begin
      sum_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_sum) begin
      bound <= bound_next;
    end
  end

  // Only k up to the count matters; an earlier failure takes precedence.
  always_comb begin
    logic fail;
    fail = 1'b0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if ((CNT_W'(k) < bound.count) && (bound.pref[k] > bound.rhs[k])) begin
        fail = 1'b1;
      end
    end
    if (bound.reason != FR_PASS) begin
      reason_next = bound.reason;
    end else if (fail) begin
      reason_next = FR_PREFIX;
    end else begin
      reason_next = FR_PASS;
    end
  end

  // Result register, held while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_out) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out) begin
      fail_reason  <= reason_next;
      is_graphical <= (reason_next == FR_PASS);
    end
  end

endmodule

`default_nettype wire

>>> src/degree_sequence_graphical_test.sv
// Erdos-Gallai graphical sequence test, five register stages deep.
// Throughput: one item per cycle; a stalled result holds the stages behind it
// only as far as they are full, so bubbles are squeezed out.
// Reset clears every stage valid bit; data registers are not reset.
`default_nettype none
`include "degree_sequence_graphical_test_defines.svh"

module degree_sequence_graphical_test
  import dsgt_pkg::*;
#(
  parameter int MAX_ENTRIES = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    ready,
  input  logic [CNT_W-1:0]        entry_count,
  input  logic signed [DEG_W-1:0] degree_0,
  input  logic signed [DEG_W-1:0] degree_1,
  input  logic signed [DEG_W-1:0] degree_2,
  input  logic signed [DEG_W-1:0] degree_3,
  input  logic signed [DEG_W-1:0] degree_4,
  input  logic signed [DEG_W-1:0] degree_5,
  input  logic signed [DEG_W-1:0] degree_6,
  input  logic signed [DEG_W-1:0] degree_7,
  input  logic signed [DEG_W-1:0] degree_8,
  input  logic signed [DEG_W-1:0] degree_9,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    is_graphical,
  output logic [1:0]              fail_reason
);

  logic [NUM_FIELDS-1:0][DEG_W-1:0] raw_deg;
  logic       v1, v2, v3, v4, v5;
  logic       adv1, adv2, adv3, adv4, adv5;
  dsgt_item_t item1;
  dsgt_item_t item3;

  assign raw_deg = {degree_9, degree_8, degree_7, degree_6, degree_5,
                    degree_4, degree_3, degree_2, degree_1, degree_0};

  // A stage moves on when it is empty or the stage after it moves on.
  assign adv5  = !v5 || result_ready;
  assign adv4  = !v4 || adv5;
  assign adv3  = !v3 || adv4;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;
  assign ready = adv1;
  assign result_valid = v5;

  dsgt_check #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .advance     (adv1),
    .in_valid    (valid),
    .entry_count (entry_count),
    .raw_deg     (raw_deg),
    .stage_valid (v1),
    .stage_item  (item1)
  );

  dsgt_sort u_sort (
    .clk             (clk),
    .rst             (rst),
    .advance_rank    (adv2),
    .advance_scatter (adv3),
    .in_valid        (v1),
    .in_item         (item1),
    .rank_valid      (v2),
    .sorted_valid    (v3),
    .sorted_item     (item3)
  );

  dsgt_ineq u_ineq (
    .clk          (clk),
    .rst          (rst),
    .advance_sum  (adv4),
    .advance_out  (adv5),
    .in_valid     (v3),
    .in_item      (item3),
    .sum_valid    (v4),
    .out_valid    (v5),
    .is_graphical (is_graphical),
    .fail_reason  (fail_reason)
  );

  // The flag and the failure code always agree.
  `DSGT_ASSERT_IMPLIES(a_flag_matches, clk, rst, result_valid, is_graphical == (fail_reason == FR_PASS))
  // With the result register empty, nothing can hold back a new item.
  `DSGT_ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !result_valid, ready)
  // A full pipeline that is not drained refuses input.
  `DSGT_ASSERT_HOLDS(a_full_stall, clk, rst, !(v1 && v2 && v3 && v4 && v5 && !result_ready && ready))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the Erdos-Gallai degree sequence test block.
// Depends on dsgt_pkg for field widths and failure codes; drives the block
// through valid/ready on both sides and checks every result in order.
module tb;
  import dsgt_pkg::*;

  localparam int MAX_ENTRIES = 10;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CALM_FROM = 1400;

  typedef logic [NUM_FIELDS-1:0][DEG_W-1:0] deg_row_t;

  typedef struct packed {
    logic       flag;
    logic [1:0] reason;
  } verdict_t;

  // Holds the verdicts still owed by the block, oldest first.
  class graph_scoreboard;
    verdict_t owed[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Erdos-Gallai test on the used degrees; returns the first failing check.
    function logic [1:0] graphical_reason(logic [CNT_W-1:0] cnt, deg_row_t d);
      int n;
      int v[NUM_FIELDS];
      int sum;
      int pref;
      int rhs;
      int tmp;
      int i;
      int j;
      int k;
      n = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;
      sum = 0;
      for (i = 0; i < NUM_FIELDS; i++) v[i] = 0;
      for (i = 0; i < n; i++) begin
        if (d[i][DEG_W-1] || d[i] >= n) return FR_RANGE;
        v[i] = d[i];
        sum += v[i];
      end
      if (sum % 2 != 0) return FR_ODD;
      // Descending insertion sort of the used degrees.
      for (i = 1; i < n; i++) begin
        tmp = v[i];
        j = i;
        while (j > 0 && v[j-1] < tmp) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = tmp;
      end
      pref = 0;
      for (k = 1; k <= n; k++) begin
        pref += v[k-1];
        rhs = k * (k - 1);
        for (i = k; i < n; i++) rhs += (v[i] < k) ? v[i] : k;
        if (pref > rhs) return FR_PREFIX;
      end
      return FR_PASS;
    endfunction

    // An item has been accepted: work out the verdict it must produce.
    function void note(logic [CNT_W-1:0] cnt, deg_row_t d);
      verdict_t vd;
      vd.reason = graphical_reason(cnt, d);
      vd.flag = (vd.reason == FR_PASS);
      owed.insert(owed.size(), vd);
    endfunction

    // A result has been accepted: compare it with the oldest verdict owed.
    function void check(logic flag, logic [1:0] reason);
      verdict_t vd;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, is_graphical %0d fail_reason %0d",
                 $time, flag, reason);
        errors++;
        return;
      end
      vd = owed.pop_front();
      if (flag !== vd.flag) begin
        $display("%0t: is_graphical mismatch, expected %0d, actual %0d",
                 $time, vd.flag, flag);
        errors++;
      end
      if (reason !== vd.reason) begin
        $display("%0t: fail_reason mismatch, expected %0d, actual %0d",
                 $time, vd.reason, reason);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [CNT_W-1:0] entry_count = '0;
  logic signed [DEG_W-1:0] degree_0 = '0;
  logic signed [DEG_W-1:0] degree_1 = '0;
  logic signed [DEG_W-1:0] degree_2 = '0;
  logic signed [DEG_W-1:0] degree_3 = '0;
  logic signed [DEG_W-1:0] degree_4 = '0;
  logic signed [DEG_W-1:0] degree_5 = '0;
  logic signed [DEG_W-1:0] degree_6 = '0;
  logic signed [DEG_W-1:0] degree_7 = '0;
  logic signed [DEG_W-1:0] degree_8 = '0;
  logic signed [DEG_W-1:0] degree_9 = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic is_graphical;
  logic [1:0] fail_reason;

  graph_scoreboard sb;
  bit calm = 1'b0;
  int hold_left = 0;

  degree_sequence_graphical_test #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .ready(ready),
    .entry_count(entry_count),
    .degree_0(degree_0),
    .degree_1(degree_1),
    .degree_2(degree_2),
    .degree_3(degree_3),
    .degree_4(degree_4),
    .degree_5(degree_5),
    .degree_6(degree_6),
    .degree_7(degree_7),
    .degree_8(degree_8),
    .degree_9(degree_9),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .is_graphical(is_graphical),
    .fail_reason(fail_reason)
  );

  // Free-running clock with a period of ten units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted item and stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) sb.check(is_graphical, fail_reason);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 13);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic [CNT_W-1:0] cnt, input deg_row_t d);
    valid <= 1'b1;
    entry_count <= cnt;
    degree_0 <= d[0];
    degree_1 <= d[1];
    degree_2 <= d[2];
    degree_3 <= d[3];
    degree_4 <= d[4];
    degree_5 <= d[5];
    degree_6 <= d[6];
    degree_7 <= d[7];
    degree_8 <= d[8];
    degree_9 <= d[9];
    @(posedge clk);
    while (!ready) @(posedge clk);
    sb.note(cnt, d);
  endtask

  task automatic send_degrees(input int cnt, input int v0 = 0, input int v1 = 0,
                              input int v2 = 0, input int v3 = 0, input int v4 = 0,
                              input int v5 = 0, input int v6 = 0, input int v7 = 0,
                              input int v8 = 0, input int v9 = 0);
    deg_row_t d;
    d[0] = v0[DEG_W-1:0];
    d[1] = v1[DEG_W-1:0];
    d[2] = v2[DEG_W-1:0];
    d[3] = v3[DEG_W-1:0];
    d[4] = v4[DEG_W-1:0];
    d[5] = v5[DEG_W-1:0];
    d[6] = v6[DEG_W-1:0];
    d[7] = v7[DEG_W-1:0];
    d[8] = v8[DEG_W-1:0];
    d[9] = v9[DEG_W-1:0];
    send_item(cnt[CNT_W-1:0], d);
  endtask

  task automatic pause_sender(input int cycles);
    valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Degrees of a random simple graph on n vertices, sometimes disturbed.
  function automatic deg_row_t random_graph(input int n);
    deg_row_t d;
    int p;
    int i;
    int j;
    for (i = 0; i < NUM_FIELDS; i++) d[i] = DEG_W'($urandom());
    for (i = 0; i < n; i++) d[i] = '0;
    p = $urandom_range(0, 100);
    for (i = 0; i < n; i++)
      for (j = i + 1; j < n; j++)
        if ($urandom_range(0, 99) < p) begin
          d[i] = d[i] + 1'b1;
          d[j] = d[j] + 1'b1;
        end
    // Move one unit of degree between two vertices, keeping the sum even.
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      if (d[i] < n - 1 && d[j] > 0) begin
        d[i] = d[i] + 1'b1;
        d[j] = d[j] - 1'b1;
      end
    end
    return d;
  endfunction

  // In-range degrees, mostly with an even sum.
  function automatic deg_row_t random_in_range(input int n);
    deg_row_t d;
    int sum;
    int i;
    for (i = 0; i < NUM_FIELDS; i++) d[i] = DEG_W'($urandom());
    sum = 0;
    for (i = 0; i < n; i++) begin
      d[i] = DEG_W'($urandom_range(0, n - 1));
      sum += d[i];
    end
    if (sum % 2 != 0 && $urandom_range(0, 4) != 0) begin
      if (d[0] > 0) d[0] = d[0] - 1'b1;
      else if (n > 1) d[0] = d[0] + 1'b1;
    end
    return d;
  endfunction

  // Run end watchdog.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus.
  initial begin
    int idx;
    int kind;
    int n;
    logic [CNT_W-1:0] cnt;
    deg_row_t d;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items: boundaries, each check and the special cases.
    send_degrees(0, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_degrees(1, 0, 15, -16);
    send_degrees(1, 1);
    send_degrees(1, -1);
    send_degrees(2, 1, 1);
    send_degrees(2, 1, 0);
    send_degrees(2, 15, 0);
    send_degrees(3, 2, 2, 2, -1, -1, -1, -1, -1, -1, -1);
    send_degrees(4, 3, 3, 1, 1);
    send_degrees(4, 3, 2, 2, 1);
    send_degrees(5, 4, 4, 4, 4, 4);
    send_degrees(5, 4, 4, 4, 4, 0);
    send_degrees(6, 5, 5, 5, 1, 1, 1);
    send_degrees(9, 8, 8, 8, 8, 8, 8, 8, 8, 8, 15);
    send_degrees(10, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9);
    send_degrees(10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_degrees(10, 9, 9, 0, 0, 0, 0, 0, 0, 0, 0);
    send_degrees(10, -16, -16, -16, -16, -16, -16, -16, -16, -16, -16);
    send_degrees(10, 15, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    send_degrees(15, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9);
    send_degrees(12, 9, 9, 9, 9, 9, 9, 9, 9, 9, 15);
    send_degrees(11, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    wait_drained();

    // Random items: mostly well-formed sequences, the rest noise.
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      calm = (idx >= CALM_FROM);
      if (idx == RANDOM_ITEMS / 2) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        n = $urandom_range(0, MAX_ENTRIES);
        d = random_graph(n);
        cnt = CNT_W'(n);
        if (n == MAX_ENTRIES && $urandom_range(0, 2) == 0)
          cnt = CNT_W'($urandom_range(MAX_ENTRIES, 15));
      end else if (kind <= 6) begin
        n = $urandom_range(1, MAX_ENTRIES);
        d = random_in_range(n);
        cnt = CNT_W'(n);
      end else begin
        d = deg_row_t'({$urandom(), $urandom()});
        cnt = CNT_W'($urandom());
      end
      send_item(cnt, d);
      if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
    end

    // Let the pipeline empty, then give the verdict.
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
